// ===== hw/rtl/y2r_pkg.sv =====
// Shared types, constants and helpers for the YUYV to RGB converter.
`timescale 1ns / 1ps

package y2r_pkg;

    localparam int unsigned PixW  = 8;   // width of one sample or channel
    localparam int unsigned OfsW  = 9;   // signed luma/chroma offset
    localparam int unsigned CoefW = 12;  // signed coefficient
    localparam int unsigned SumW  = 21;  // signed product and channel sum
    localparam int unsigned QuoW  = 15;  // sum with the divide-by-8 applied
    localparam int unsigned RecW  = 16;  // reciprocal of 125
    localparam int unsigned ProdW = 31;  // quotient product
    localparam int unsigned RecSh = 22;  // reciprocal scaling shift

    localparam logic signed [CoefW-1:0] C_Y  = 12'sd1164;
    localparam logic signed [CoefW-1:0] C_RV = 12'sd1596;
    localparam logic signed [CoefW-1:0] C_GV = 12'sd813;
    localparam logic signed [CoefW-1:0] C_GU = 12'sd391;
    localparam logic signed [CoefW-1:0] C_BU = 12'sd2018;

    localparam logic signed [OfsW-1:0] LUMA_OFS   = 9'sd16;
    localparam logic signed [OfsW-1:0] CHROMA_OFS = 9'sd128;

    // sum / 1000 = (sum >> 3) / 125; 125 is reached by ceil(2^22 / 125)
    localparam logic [RecW-1:0] REC_125 = 16'd33555;
    // first sum whose quotient exceeds full scale
    localparam logic signed [SumW-1:0] SUM_SAT = 21'sd256000;

    localparam logic [PixW-1:0] PIX_MAX = 8'd255;
    localparam logic [PixW-1:0] PIX_MIN = 8'd0;

    // one pixel entering the colour pipeline
    typedef struct packed {
        logic            valid;
        logic            last;
        logic [PixW-1:0] luma;
        logic [PixW-1:0] cb;
        logic [PixW-1:0] cr;
    } t_pix_in;

    // signed coefficient times signed offset, full precision
    function automatic logic signed [SumW-1:0] mul_coef(
        input logic signed [OfsW-1:0]  x,
        input logic signed [CoefW-1:0] c
    );
        logic signed [SumW-1:0] xe;
        logic signed [SumW-1:0] ce;
        xe = SumW'(x);
        ce = SumW'(c);
        return xe * ce;
    endfunction

endpackage

// ===== hw/rtl/y2r_pair_split.sv =====
// Splits one accepted macropixel into two pixels, one per cycle.
`timescale 1ns / 1ps

module y2r_pair_split (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [y2r_pkg::PixW-1:0] i_luma_first,
    input  logic [y2r_pkg::PixW-1:0] i_chroma_blue,
    input  logic [y2r_pkg::PixW-1:0] i_luma_second,
    input  logic [y2r_pkg::PixW-1:0] i_chroma_red,
    output logic                     o_busy,
    output y2r_pkg::t_pix_in         o_pix
);

    logic                     r_hold;
    logic                     n_hold;
    logic [y2r_pkg::PixW-1:0] r_luma;
    logic [y2r_pkg::PixW-1:0] r_cb;
    logic [y2r_pkg::PixW-1:0] r_cr;
    logic                     w_accept;

    assign o_busy   = r_hold;
    assign w_accept = i_start && !r_hold;
    assign n_hold   = w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
        end else begin
            r_hold <= n_hold;
        end
    end

    // hold the second luma and shared chroma for the following cycle
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_luma <= i_luma_second;
            r_cb   <= i_chroma_blue;
            r_cr   <= i_chroma_red;
        end
    end

    always_comb begin
        if (r_hold) begin
            o_pix.valid = 1'b1;
            o_pix.last  = 1'b1;
            o_pix.luma  = r_luma;
            o_pix.cb    = r_cb;
            o_pix.cr    = r_cr;
        end else begin
            o_pix.valid = w_accept;
            o_pix.last  = 1'b0;
            o_pix.luma  = i_luma_first;
            o_pix.cb    = i_chroma_blue;
            o_pix.cr    = i_chroma_red;
        end
    end

endmodule

// ===== hw/rtl/y2r_color_pipe.sv =====
// Five-stage BT.601 colour conversion pipeline, one pixel per cycle.
`timescale 1ns / 1ps

module y2r_color_pipe (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  y2r_pkg::t_pix_in         i_pix,
    output logic                     o_valid,
    output logic [y2r_pkg::PixW-1:0] o_red,
    output logic [y2r_pkg::PixW-1:0] o_green,
    output logic [y2r_pkg::PixW-1:0] o_blue,
    output logic                     o_last_of_pair
);

    localparam int unsigned NumCh = 3; // red, green, blue

    // stage 1: offsets
    logic                             r_s1_valid;
    logic                             r_s1_last;
    logic signed [y2r_pkg::OfsW-1:0]  r_s1_y;
    logic signed [y2r_pkg::OfsW-1:0]  r_s1_u;
    logic signed [y2r_pkg::OfsW-1:0]  r_s1_v;

    // stage 2: products
    logic                             r_s2_valid;
    logic                             r_s2_last;
    logic signed [y2r_pkg::SumW-1:0]  r_s2_ys;
    logic signed [y2r_pkg::SumW-1:0]  r_s2_rv;
    logic signed [y2r_pkg::SumW-1:0]  r_s2_gv;
    logic signed [y2r_pkg::SumW-1:0]  r_s2_gu;
    logic signed [y2r_pkg::SumW-1:0]  r_s2_bu;

    // stage 3: channel sums
    logic                             r_s3_valid;
    logic                             r_s3_last;
    logic signed [y2r_pkg::SumW-1:0]  r_s3_sum [NumCh];

    // stage 4: reciprocal products and range flags
    logic                             r_s4_valid;
    logic                             r_s4_last;
    logic [y2r_pkg::ProdW-1:0]        r_s4_prod [NumCh];
    logic [NumCh-1:0]                 r_s4_neg;
    logic [NumCh-1:0]                 r_s4_sat;

    logic [y2r_pkg::PixW-1:0]         n_chan [NumCh];
    logic [y2r_pkg::PixW-1:0]         r_chan [NumCh];
    logic                             r_valid;
    logic                             r_last;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_s1_valid <= i_pix.valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_valid    <= r_s4_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s1_last <= i_pix.last;
        r_s1_y    <= $signed({1'b0, i_pix.luma}) - y2r_pkg::LUMA_OFS;
        r_s1_u    <= $signed({1'b0, i_pix.cb}) - y2r_pkg::CHROMA_OFS;
        r_s1_v    <= $signed({1'b0, i_pix.cr}) - y2r_pkg::CHROMA_OFS;

        r_s2_last <= r_s1_last;
        r_s2_ys   <= y2r_pkg::mul_coef(r_s1_y, y2r_pkg::C_Y);
        r_s2_rv   <= y2r_pkg::mul_coef(r_s1_v, y2r_pkg::C_RV);
        r_s2_gv   <= y2r_pkg::mul_coef(r_s1_v, y2r_pkg::C_GV);
        r_s2_gu   <= y2r_pkg::mul_coef(r_s1_u, y2r_pkg::C_GU);
        r_s2_bu   <= y2r_pkg::mul_coef(r_s1_u, y2r_pkg::C_BU);

        r_s3_last   <= r_s2_last;
        r_s3_sum[0] <= r_s2_ys + r_s2_rv;
        r_s3_sum[1] <= r_s2_ys - r_s2_gv - r_s2_gu;
        r_s3_sum[2] <= r_s2_ys + r_s2_bu;

        r_s4_last <= r_s3_last;
        r_last    <= r_s4_last;
    end

    // divide by 1000 as (sum >> 3) * ceil(2^22 / 125) >> 22; only sums in
    // 0..255999 use the quotient, so bits 17:3 carry the whole value
    for (genvar ch = 0; ch < NumCh; ch++) begin : g_chan
        always_ff @(posedge i_clk) begin
            r_s4_neg[ch]  <= r_s3_sum[ch][y2r_pkg::SumW-1];
            r_s4_sat[ch]  <= !r_s3_sum[ch][y2r_pkg::SumW-1]
                             && (r_s3_sum[ch] >= y2r_pkg::SUM_SAT);
            r_s4_prod[ch] <= y2r_pkg::ProdW'(r_s3_sum[ch][y2r_pkg::QuoW+2:3])
                             * y2r_pkg::ProdW'(y2r_pkg::REC_125);
        end

        always_comb begin
            priority if (r_s4_neg[ch]) begin
                n_chan[ch] = y2r_pkg::PIX_MIN;
            end else if (r_s4_sat[ch]) begin
                n_chan[ch] = y2r_pkg::PIX_MAX;
            end else begin
                n_chan[ch] = r_s4_prod[ch][y2r_pkg::RecSh+y2r_pkg::PixW-1:y2r_pkg::RecSh];
            end
        end

        always_ff @(posedge i_clk) begin
            r_chan[ch] <= n_chan[ch];
        end
    end

    assign o_valid        = r_valid;
    assign o_last_of_pair = r_last;
    assign o_red          = r_chan[0];
    assign o_green        = r_chan[1];
    assign o_blue         = r_chan[2];

endmodule

// ===== hw/rtl/yuyv_to_rgb_converter.sv =====
// Top level of the YUYV (4:2:2) to RGB converter, BT.601 studio range.
//
//  channel   handshake          payload
//  --------  -----------------  ---------------------------------------------
//  input     i_start / o_busy   i_luma_first, i_chroma_blue, i_luma_second,
//                               i_chroma_red
//  result    o_valid (strobe)   o_red, o_green, o_blue, o_last_of_pair
//
// An item is taken on a rising edge with i_start high and o_busy low. Each
// item yields two pixels; the pair splitter feeds the colour pipeline one
// pixel per cycle, so o_busy rises for the cycle after every accepted item
// and no new item is taken until the second pixel has entered the pipeline.
// The first pixel passes the offset, product, sum, reciprocal and output
// registers, and the second (o_last_of_pair high) follows it in the next cycle.
// Synchronous active-low reset clears the pair splitter and every valid bit
// of the pipeline; data registers are not reset.
// The receiver takes every strobed pixel, so the pipeline never stalls.
`timescale 1ns / 1ps

module yuyv_to_rgb_converter (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [y2r_pkg::PixW-1:0] i_luma_first,
    input  logic [y2r_pkg::PixW-1:0] i_chroma_blue,
    input  logic [y2r_pkg::PixW-1:0] i_luma_second,
    input  logic [y2r_pkg::PixW-1:0] i_chroma_red,
    output logic                     o_valid,
    output logic [y2r_pkg::PixW-1:0] o_red,
    output logic [y2r_pkg::PixW-1:0] o_green,
    output logic [y2r_pkg::PixW-1:0] o_blue,
    output logic                     o_last_of_pair
);

    // one pixel per cycle from the splitter into the pipeline
    y2r_pkg::t_pix_in w_pix;

    // Hold the second luma and the shared chroma while the
    // first pixel enters the pipeline.
    y2r_pair_split u_split (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_luma_first  (i_luma_first),
        .i_chroma_blue (i_chroma_blue),
        .i_luma_second (i_luma_second),
        .i_chroma_red  (i_chroma_red),
        .o_busy        (o_busy),
        .o_pix         (w_pix)
    );

    // Offsets, coefficient products, channel sums, reciprocal divide, then
    // clamp into the output registers; valid advances with each pixel.
    y2r_color_pipe u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pix          (w_pix),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_last_of_pair (o_last_of_pair)
    );

endmodule

// ===== dv/yuyv_to_rgb_converter_tb.sv =====
// Self-checking testbench for the YUYV to RGB converter: directed corners, then random streams.
`timescale 1ns / 1ps

module yuyv_to_rgb_converter_tb;

    // BT.601 studio-range coefficients, scaled by a thousand
    localparam int CoefLuma     = 1164;
    localparam int CoefRedCr    = 1596;
    localparam int CoefGreenCr  = 813;
    localparam int CoefGreenCb  = 391;
    localparam int CoefBlueCb   = 2018;
    localparam int ColourScale  = 1000;
    localparam int LumaBlack    = 16;
    localparam int ChromaCentre = 128;

    localparam int unsigned MaxReports = 10;
    localparam int unsigned DrainLimit = 200;  // cycles allowed for the pipeline to empty
    localparam int unsigned TailCycles = 10;   // extra cycles run after the pending queue empties

    typedef struct packed {
        logic [y2r_pkg::PixW-1:0] red;
        logic [y2r_pkg::PixW-1:0] green;
        logic [y2r_pkg::PixW-1:0] blue;
        logic                     last;
    } t_rgb_pixel;

    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_start        = 1'b0;
    logic [y2r_pkg::PixW-1:0] i_luma_first   = '0;
    logic [y2r_pkg::PixW-1:0] i_chroma_blue  = '0;
    logic [y2r_pkg::PixW-1:0] i_luma_second  = '0;
    logic [y2r_pkg::PixW-1:0] i_chroma_red   = '0;
    logic                     o_busy;
    logic                     o_valid;
    logic [y2r_pkg::PixW-1:0] o_red;
    logic [y2r_pkg::PixW-1:0] o_green;
    logic [y2r_pkg::PixW-1:0] o_blue;
    logic                     o_last_of_pair;

    // pixels owed by the converter, oldest first
    t_rgb_pixel  pending_pixels[$];
    int unsigned mismatch_count  = 0;
    // chance, in percent, that the sender adds another idle cycle
    int unsigned sender_idle_pct = 0;

    yuyv_to_rgb_converter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_luma_first   (i_luma_first),
        .i_chroma_blue  (i_chroma_blue),
        .i_luma_second  (i_luma_second),
        .i_chroma_red   (i_chroma_red),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_last_of_pair (o_last_of_pair)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Divide by the scale (truncating toward zero), then clamp to one byte.
    function automatic logic [y2r_pkg::PixW-1:0] clamp_to_byte(input int sum);
        int quo;
        quo = sum / ColourScale;
        if (quo < 0) return y2r_pkg::PIX_MIN;
        if (quo > 255) return y2r_pkg::PIX_MAX;
        return quo[y2r_pkg::PixW-1:0];
    endfunction

    // Colour one pixel from its luma and the shared chroma pair.
    function automatic t_rgb_pixel convert_pixel(input logic [y2r_pkg::PixW-1:0] luma,
                                                 input logic [y2r_pkg::PixW-1:0] cb,
                                                 input logic [y2r_pkg::PixW-1:0] cr,
                                                 input logic                     last);
        int         luma_term;
        int         cb_ofs;
        int         cr_ofs;
        t_rgb_pixel px;
        luma_term = CoefLuma * (int'(luma) - LumaBlack);
        cb_ofs    = int'(cb) - ChromaCentre;
        cr_ofs    = int'(cr) - ChromaCentre;
        px.red    = clamp_to_byte(luma_term + CoefRedCr * cr_ofs);
        px.green  = clamp_to_byte(luma_term - CoefGreenCr * cr_ofs - CoefGreenCb * cb_ofs);
        px.blue   = clamp_to_byte(luma_term + CoefBlueCb * cb_ofs);
        px.last   = last;
        return px;
    endfunction

    task automatic report_failure(input string what, input t_rgb_pixel want,
                                  input t_rgb_pixel got);
        mismatch_count++;
        if (mismatch_count <= MaxReports)
            $display("%0t: %s: expected R=%0d G=%0d B=%0d last=%0b, got R=%0d G=%0d B=%0d last=%0b",
                     $realtime, what, want.red, want.green, want.blue, want.last,
                     got.red, got.green, got.blue, got.last);
    endtask

    // Present one macropixel and hold it until taken, then log the two pixels
    // it owes. Start is left high so that back-to-back items need no gap; an
    // idle stretch drops it for a random number of cycles.
    task automatic send_macropixel(input logic [y2r_pkg::PixW-1:0] luma_a,
                                   input logic [y2r_pkg::PixW-1:0] cb,
                                   input logic [y2r_pkg::PixW-1:0] luma_b,
                                   input logic [y2r_pkg::PixW-1:0] cr);
        i_start       <= 1'b1;
        i_luma_first  <= luma_a;
        i_chroma_blue <= cb;
        i_luma_second <= luma_b;
        i_chroma_red  <= cr;
        do
            @(posedge i_clk);
        while (o_busy);
        pending_pixels.push_back(convert_pixel(luma_a, cb, cr, 1'b0));
        pending_pixels.push_back(convert_pixel(luma_b, cb, cr, 1'b1));
        while ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // Favour the ends of the range so that clamping is hit often.
    function automatic logic [y2r_pkg::PixW-1:0] pick_sample();
        unique case ($urandom_range(9))
            0: return y2r_pkg::PIX_MIN;
            1: return y2r_pkg::PIX_MAX;
            default: return y2r_pkg::PixW'($urandom_range(255));
        endcase
    endfunction

    // Black, white and grey levels with neutral chroma, some coloured pixels,
    // and two different lumas in one pair so that the order of the two pixels shows.
    task automatic test_reference_levels();
        send_macropixel(8'd16,  8'd128, 8'd235, 8'd128);
        send_macropixel(8'd235, 8'd128, 8'd16,  8'd128);
        send_macropixel(8'd126, 8'd128, 8'd127, 8'd128);
        send_macropixel(8'd81,  8'd90,  8'd145, 8'd240);
        send_macropixel(8'd41,  8'd240, 8'd210, 8'd110);
        send_macropixel(8'd170, 8'd16,  8'd60,  8'd146);
        send_macropixel(8'd85,  8'd170, 8'd170, 8'd85);
    endtask

    // Negative sums, including ones just below zero, and sums just over full
    // scale; every field at both extremes so each bit takes both values.
    task automatic test_clamping();
        send_macropixel(8'd0,   8'd0,   8'd255, 8'd0);
        send_macropixel(8'd255, 8'd255, 8'd0,   8'd255);
        send_macropixel(8'd0,   8'd255, 8'd255, 8'd255);
        send_macropixel(8'd255, 8'd0,   8'd0,   8'd0);
        send_macropixel(8'd16,  8'd127, 8'd16,  8'd127);
        send_macropixel(8'd16,  8'd129, 8'd17,  8'd129);
        send_macropixel(8'd236, 8'd128, 8'd235, 8'd128);
        send_macropixel(8'd200, 8'd200, 8'd220, 8'd200);
        send_macropixel(8'd255, 8'd128, 8'd240, 8'd130);
        send_macropixel(8'd10,  8'd60,  8'd30,  8'd60);
        send_macropixel(8'd85,  8'd85,  8'd170, 8'd170);
    endtask

    task automatic test_random_stream(input int unsigned count, input int unsigned idle_pct);
        sender_idle_pct = idle_pct;
        repeat (count)
            send_macropixel(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    // Compare every strobed pixel with the oldest one owed. Outputs are read
    // at the edge that ends the strobe cycle, before any update at that edge.
    always @(posedge i_clk) begin : check_pixels
        t_rgb_pixel got;
        t_rgb_pixel want;
        if (i_rst_n && o_valid) begin
            got = {o_red, o_green, o_blue, o_last_of_pair};
            if (pending_pixels.size() == 0) begin
                report_failure("pixel with nothing pending", '0, got);
            end else begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.last !== want.last)
                    report_failure("pixel mismatch", want, got);
            end
        end
    end

    initial begin : run_tests
        int unsigned drain_cycles;
        // hold reset at the start, then release it once for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reference_levels();
        test_clamping();
        // flat out, then a sparse sender, then a lightly gapped one
        test_random_stream(250, 0);
        test_random_stream(250, 84);
        test_random_stream(250, 32);
        i_start <= 1'b0;

        // let the pipeline empty, bounded in case pixels go missing
        drain_cycles = 0;
        while (pending_pixels.size() != 0 && drain_cycles < DrainLimit) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (TailCycles) @(posedge i_clk);

        if (pending_pixels.size() != 0) begin
            mismatch_count += pending_pixels.size();
            $display("%0t: %0d pixels never produced", $realtime, pending_pixels.size());
        end

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
